// File: sv/gbc_pkg.sv
// Shared types and constants for the GPIO bank controller.
`default_nettype none
package gbc_pkg;

    localparam int BANK_COUNT = 4;
    localparam int BANK_W     = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
    localparam int NREG       = 9;
    localparam int CFG_W      = 8;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_PIN   = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [11:0]      WINDOW_LIMIT     = 12'h200;
    localparam logic [31:0]      CLEAR_READ_VALUE = 32'd31337;
    localparam logic [CFG_W-1:0] PIN_COUNT_RESET  = 8'd121;

    typedef enum logic [3:0] {
        REG_LEVEL,
        REG_DIR,
        REG_SET,
        REG_CLEAR,
        REG_RISE,
        REG_FALL,
        REG_EDGE,
        REG_ALT_LO,
        REG_ALT_HI
    } t_reg;

    // Byte offsets, one row per register, one column per bank
    localparam logic [11:0] REG_ADDR [NREG][4] = '{
        '{12'h000, 12'h004, 12'h008, 12'h100},
        '{12'h00c, 12'h010, 12'h014, 12'h10c},
        '{12'h018, 12'h01c, 12'h020, 12'h118},
        '{12'h024, 12'h028, 12'h02c, 12'h124},
        '{12'h030, 12'h034, 12'h038, 12'h130},
        '{12'h03c, 12'h040, 12'h044, 12'h13c},
        '{12'h048, 12'h04c, 12'h050, 12'h148},
        '{12'h054, 12'h05c, 12'h064, 12'h06c},
        '{12'h058, 12'h060, 12'h068, 12'h070}
    };

    localparam logic [31:0] WAKE_PINS [4] = '{
        32'h8003fe1b, 32'h002001fc, 32'hec080000, 32'h0012007f
    };

    typedef struct packed {
        logic [1:0]  opcode;
        logic [11:0] address;
        logic [31:0] write_data;
        logic [6:0]  pin_line;
        logic        pin_level;
        logic        cpu_halted;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic        bad_access;
        logic        level_read_pulse;
        logic        irq_pin0;
        logic        irq_pin1;
        logic        irq_other;
        logic        wake_request;
        logic [1:0]  driven_bank;
        logic [31:0] driven_levels;
    } t_rsp;

    typedef struct packed {
        logic       hit;
        t_reg       rsel;
        logic [1:0] bank;
    } t_dec;

    function automatic t_dec f_decode(input logic [11:0] addr);
        t_dec d;
        d = '{hit: 1'b0, rsel: REG_LEVEL, bank: 2'd0};
        for (int r = 0; r < NREG; r++) begin
            for (int b = 0; b < BANK_COUNT; b++) begin
                if (!d.hit && REG_ADDR[r][b] == addr) begin
                    d.hit  = 1'b1;
                    d.rsel = t_reg'(4'(r));
                    d.bank = 2'(b);
                end
            end
        end
        return d;
    endfunction

endpackage
`default_nettype wire

// File: sv/gbc_req_if.sv
// Request channel: bus access or pin level change.
`default_nettype none
interface gbc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [11:0] address;
    logic [31:0] write_data;
    logic [6:0]  pin_line;
    logic        pin_level;
    logic        cpu_halted;

    modport source (output valid, opcode, address, write_data, pin_line, pin_level,
                    cpu_halted, input ready);
    modport sink   (input valid, opcode, address, write_data, pin_line, pin_level,
                    cpu_halted, output ready);
endinterface
`default_nettype wire

// File: sv/gbc_rsp_if.sv
// Result channel: read data, flags, interrupt levels and driven pin levels.
`default_nettype none
interface gbc_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        bad_access;
    logic        level_read_pulse;
    logic        irq_pin0;
    logic        irq_pin1;
    logic        irq_other;
    logic        wake_request;
    logic [1:0]  driven_bank;
    logic [31:0] driven_levels;

    modport source (output valid, read_data, bad_access, level_read_pulse, irq_pin0,
                    irq_pin1, irq_other, wake_request, driven_bank, driven_levels,
                    input ready);
    modport sink   (input valid, read_data, bad_access, level_read_pulse, irq_pin0,
                    irq_pin1, irq_other, wake_request, driven_bank, driven_levels,
                    output ready);
endinterface
`default_nettype wire

// File: sv/gpio_bank_controller_edge_irq.sv
// Each request goes from the request register into the result register when it is free.
// Throughput: one request per cycle unless the result side stalls; the request and result
// registers form a two-entry pipe, so one more request is taken while a result waits.
// The only logic between them is address decode, bit masking and an OR tree.
// Reset (sync, active low) clears all bank registers and sets pin count to 121.
`default_nettype none
module gpio_bank_controller_edge_irq (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    gbc_req_if.sink                       i_req,
    gbc_rsp_if.source                     o_rsp,
    input  wire logic                     i_cfg_we,
    input  wire logic [gbc_pkg::CFG_W-1:0] i_cfg_wdata
);
    import gbc_pkg::*;

    logic             r_in_valid;
    t_req             r_req;
    logic             r_out_valid;
    t_rsp             r_rsp;
    t_rsp             n_rsp;
    logic [CFG_W-1:0] r_pin_count;

    logic [31:0] r_level  [BANK_COUNT];
    logic [31:0] r_latch  [BANK_COUNT];
    logic [31:0] r_dir    [BANK_COUNT];
    logic [31:0] r_rise   [BANK_COUNT];
    logic [31:0] r_fall   [BANK_COUNT];
    logic [31:0] r_edge   [BANK_COUNT];
    logic [31:0] r_setw   [BANK_COUNT];
    logic [31:0] r_alt_lo [BANK_COUNT];
    logic [31:0] r_alt_hi [BANK_COUNT];

    logic [31:0] n_level  [BANK_COUNT];
    logic [31:0] n_latch  [BANK_COUNT];
    logic [31:0] n_dir    [BANK_COUNT];
    logic [31:0] n_rise   [BANK_COUNT];
    logic [31:0] n_fall   [BANK_COUNT];
    logic [31:0] n_edge   [BANK_COUNT];
    logic [31:0] n_setw   [BANK_COUNT];
    logic [31:0] n_alt_lo [BANK_COUNT];
    logic [31:0] n_alt_hi [BANK_COUNT];

    logic              advance;
    logic              fire;
    t_dec              dec;
    logic [BANK_W-1:0] bi;
    logic [BANK_W-1:0] pi;
    logic [1:0]        pin_bank;
    logic [31:0]       pin_mask;
    logic              pin_ok;
    logic [31:0]       rest;
    logic [1:0]        rep_bank;
    logic [BANK_W-1:0] rep_idx;

    assign advance     = !r_out_valid || o_rsp.ready;
    assign fire        = r_in_valid && advance;
    assign i_req.ready = !r_in_valid || advance;

    assign dec      = f_decode(r_req.address);
    assign bi       = dec.bank[BANK_W-1:0];
    assign pin_bank = r_req.pin_line[6:5];
    assign pi       = pin_bank[BANK_W-1:0];
    assign pin_mask = 32'd1 << r_req.pin_line[4:0];
    assign pin_ok   = ({1'b0, r_req.pin_line} < r_pin_count)
                      && (int'(pin_bank) < BANK_COUNT);

    always_comb begin
        n_level  = r_level;
        n_latch  = r_latch;
        n_dir    = r_dir;
        n_rise   = r_rise;
        n_fall   = r_fall;
        n_edge   = r_edge;
        n_setw   = r_setw;
        n_alt_lo = r_alt_lo;
        n_alt_hi = r_alt_hi;
        n_rsp    = '0;
        rep_bank = 2'd0;

        if ((r_req.opcode == OP_READ || r_req.opcode == OP_WRITE)
                && r_req.address < WINDOW_LIMIT) begin
            if (!dec.hit) begin
                n_rsp.bad_access = 1'b1;
            end else begin
                rep_bank = dec.bank;
                if (r_req.opcode == OP_READ) begin
                    unique case (dec.rsel)
                        REG_LEVEL: begin
                            n_rsp.read_data = (r_latch[bi] & r_dir[bi])
                                              | (r_level[bi] & ~r_dir[bi]);
                            n_rsp.level_read_pulse = 1'b1;
                        end
                        REG_DIR:    n_rsp.read_data = r_dir[bi];
                        REG_SET:    n_rsp.read_data = r_setw[bi];
                        REG_CLEAR:  n_rsp.read_data = CLEAR_READ_VALUE;
                        REG_RISE:   n_rsp.read_data = r_rise[bi];
                        REG_FALL:   n_rsp.read_data = r_fall[bi];
                        REG_EDGE:   n_rsp.read_data = r_edge[bi];
                        REG_ALT_LO: n_rsp.read_data = r_alt_lo[bi];
                        REG_ALT_HI: n_rsp.read_data = r_alt_hi[bi];
                        default:    n_rsp.read_data = '0;
                    endcase
                end else begin
                    unique case (dec.rsel)
                        REG_LEVEL: ;
                        REG_DIR:   n_dir[bi] = r_req.write_data;
                        REG_SET: begin
                            n_latch[bi] = r_latch[bi] | r_req.write_data;
                            n_setw[bi]  = r_req.write_data;
                        end
                        REG_CLEAR:  n_latch[bi] = r_latch[bi] & ~r_req.write_data;
                        REG_RISE:   n_rise[bi] = r_req.write_data;
                        REG_FALL:   n_fall[bi] = r_req.write_data;
                        REG_EDGE:   n_edge[bi] = r_edge[bi] & ~r_req.write_data;
                        REG_ALT_LO: n_alt_lo[bi] = r_req.write_data;
                        REG_ALT_HI: n_alt_hi[bi] = r_req.write_data;
                        default: ;
                    endcase
                end
            end
        end else if (r_req.opcode == OP_PIN && pin_ok) begin
            rep_bank = pin_bank;
            if (r_req.pin_level) begin
                n_edge[pi]  = r_edge[pi]
                              | (r_rise[pi] & pin_mask & ~r_level[pi] & ~r_dir[pi]);
                n_level[pi] = r_level[pi] | pin_mask;
            end else begin
                n_edge[pi]  = r_edge[pi]
                              | (r_fall[pi] & pin_mask & r_level[pi] & ~r_dir[pi]);
                n_level[pi] = r_level[pi] & ~pin_mask;
            end
            n_rsp.wake_request = r_req.cpu_halted
                                 && ((pin_mask & ~r_dir[pi] & WAKE_PINS[pin_bank]) != '0);
        end

        // Interrupt levels follow the updated edge status
        rest = n_edge[0] & ~32'h3;
        for (int b = 1; b < BANK_COUNT; b++) begin
            rest = rest | n_edge[b];
        end
        n_rsp.irq_pin0      = n_edge[0][0];
        n_rsp.irq_pin1      = n_edge[0][1];
        n_rsp.irq_other     = (rest != '0);
        n_rsp.driven_bank   = rep_bank;
        n_rsp.driven_levels = n_latch[rep_idx] & n_dir[rep_idx];
    end

    assign rep_idx = rep_bank[BANK_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pin_count <= PIN_COUNT_RESET;
            for (int b = 0; b < BANK_COUNT; b++) begin
                r_level[b]  <= '0;
                r_latch[b]  <= '0;
                r_dir[b]    <= '0;
                r_rise[b]   <= '0;
                r_fall[b]   <= '0;
                r_edge[b]   <= '0;
                r_setw[b]   <= '0;
                r_alt_lo[b] <= '0;
                r_alt_hi[b] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_pin_count <= i_cfg_wdata;
            end
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_level  <= n_level;
                r_latch  <= n_latch;
                r_dir    <= n_dir;
                r_rise   <= n_rise;
                r_fall   <= n_fall;
                r_edge   <= n_edge;
                r_setw   <= n_setw;
                r_alt_lo <= n_alt_lo;
                r_alt_hi <= n_alt_hi;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_req.opcode     <= i_req.opcode;
            r_req.address    <= i_req.address;
            r_req.write_data <= i_req.write_data;
            r_req.pin_line   <= i_req.pin_line;
            r_req.pin_level  <= i_req.pin_level;
            r_req.cpu_halted <= i_req.cpu_halted;
        end
        if (fire) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.read_data        = r_rsp.read_data;
    assign o_rsp.bad_access       = r_rsp.bad_access;
    assign o_rsp.level_read_pulse = r_rsp.level_read_pulse;
    assign o_rsp.irq_pin0         = r_rsp.irq_pin0;
    assign o_rsp.irq_pin1         = r_rsp.irq_pin1;
    assign o_rsp.irq_other        = r_rsp.irq_other;
    assign o_rsp.wake_request     = r_rsp.wake_request;
    assign o_rsp.driven_bank      = r_rsp.driven_bank;
    assign o_rsp.driven_levels    = r_rsp.driven_levels;

`ifndef SYNTH
    // A pending request moves into the result register whenever the result side frees up
    a_pipe_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance) |=> r_out_valid)
        else $error("pending request did not reach result register");

    // An undecoded access returns no data and no level read pulse
    a_bad_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rsp.bad_access) |->
            (r_rsp.read_data == '0 && !r_rsp.level_read_pulse && !r_rsp.wake_request))
        else $error("bad access result carries data");

    // Wake only comes from a pin event, never alongside read data
    a_wake_pin_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rsp.wake_request) |->
            (r_rsp.read_data == '0 && !r_rsp.level_read_pulse))
        else $error("wake request on a bus access");
`endif

endmodule
`default_nettype wire
